// ===== src/dac_pkg.sv =====
// shared constants and types of the dipole angular coefficient block
`timescale 1ns / 1ps
package dac_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W = 14;
  localparam int QUO_W = 2 * FRAC_BITS + 2;
  localparam int ROOT_W = FRAC_BITS + 1;
  localparam int SREM_W = ROOT_W + 2;
  localparam int COEF_W = 17;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic bad;
    logic neg;
    logic imag;
  } meta_t;
endpackage

// ===== src/dac_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface dac_req_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [5:0] l_bra;
  logic signed [6:0] m_bra;
  logic [5:0] l_ket;
  logic signed [6:0] m_ket;
  modport source (output valid, operation, l_bra, m_bra, l_ket, m_ket, input ready);
  modport sink (input valid, operation, l_bra, m_bra, l_ket, m_ket, output ready);
endinterface

interface dac_rsp_if;
  logic valid;
  logic ready;
  logic signed [16:0] coef_real;
  logic signed [16:0] coef_imag;
  logic invalid;
  modport source (output valid, coef_real, coef_imag, invalid, input ready);
  modport sink (input valid, coef_real, coef_imag, invalid, output ready);
endinterface

// ===== src/dac_root.sv =====
// pipelined restoring divider followed by pipelined digit-by-digit square root
`timescale 1ns / 1ps
module dac_root
  import dac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]  den,
  input  logic              half,
  input  meta_t             in_meta,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output meta_t             out_meta
);
  logic              d_v    [QUO_W+1];
  logic [NUM_W-1:0]  d_rem  [QUO_W+1];
  logic [NUM_W-1:0]  d_den  [QUO_W+1];
  logic [QUO_W-1:0]  d_lo   [QUO_W+1];
  logic [QUO_W-1:0]  d_quo  [QUO_W+1];
  meta_t             d_meta [QUO_W+1];

  logic              s_v    [ROOT_W+1];
  logic [SREM_W-1:0] s_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] s_root [ROOT_W+1];
  logic [QUO_W-1:0]  s_q    [ROOT_W+1];
  meta_t             s_meta [ROOT_W+1];

  assign d_v[0]    = in_valid;
  assign d_rem[0]  = half ? (num >> 2) : num;
  assign d_den[0]  = den;
  assign d_lo[0]   = half ? {num[1:0], {(QUO_W-2){1'b0}}} : '0;
  assign d_quo[0]  = '0;
  assign d_meta[0] = in_meta;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    logic [NUM_W:0] trial;
    logic           fits;
    assign trial = {d_rem[i], d_lo[i][QUO_W-1]};
    assign fits  = trial >= {1'b0, d_den[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[i+1] <= 1'b0;
      end else if (en) begin
        d_v[i+1] <= d_v[i];
      end
      if (en) begin
        d_rem[i+1]  <= fits ? NUM_W'(trial - {1'b0, d_den[i]}) : trial[NUM_W-1:0];
        d_den[i+1]  <= d_den[i];
        d_lo[i+1]   <= {d_lo[i][QUO_W-2:0], 1'b0};
        d_quo[i+1]  <= {d_quo[i][QUO_W-2:0], fits};
        d_meta[i+1] <= d_meta[i];
      end
    end
  end

  assign s_v[0]    = d_v[QUO_W];
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_q[0]    = d_quo[QUO_W];
  assign s_meta[0] = d_meta[QUO_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [SREM_W+1:0] x;
    logic [SREM_W+1:0] t;
    logic              ok;
    assign x  = {s_rem[j], s_q[j][QUO_W-1:QUO_W-2]};
    assign t  = {2'b00, s_root[j], 2'b01};
    assign ok = x >= t;
    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[j+1] <= 1'b0;
      end else if (en) begin
        s_v[j+1] <= s_v[j];
      end
      if (en) begin
        s_rem[j+1]  <= ok ? SREM_W'(x - t) : x[SREM_W-1:0];
        s_root[j+1] <= {s_root[j][ROOT_W-2:0], ok};
        s_q[j+1]    <= {s_q[j][QUO_W-3:0], 2'b00};
        s_meta[j+1] <= s_meta[j];
      end
    end
  end

  assign out_valid = s_v[ROOT_W];
  assign root      = s_root[ROOT_W];
  assign out_meta  = s_meta[ROOT_W];
endmodule

// ===== src/dipole_angular_coefficient.sv =====
// top level: selection rules, coefficient pipeline and response register
// Computes the dipole coupling coefficient between two spherical harmonics.
// Requests arrive on req (axis and two l,m pairs), results leave on rsp
// (real part, imaginary part, invalid flag) with 16 fraction bits.
// Every request gives exactly one response, in request order.
// The path to rsp.valid runs through 53 registers: one decode stage
// (loaded at the accepting edge), 34 divider stages (one quotient bit each),
// 17 square root stages (one root bit each) and the response register.
// Throughput is one item per cycle; the whole pipeline advances together.
// When the receiver holds rsp.ready low with a result waiting, the pipeline
// freezes and req.ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; req.ready is high right
// after reset.
`timescale 1ns / 1ps
module dipole_angular_coefficient
  import dac_pkg::*;
(
  input logic     clk,
  input logic     rst,
  dac_req_if.sink   req,
  dac_rsp_if.source rsp
);
  logic              en;
  logic              v0;
  logic [NUM_W-1:0]  num0;
  logic [NUM_W-1:0]  den0;
  logic              half0;
  meta_t             meta0;
  logic [NUM_W-1:0]  num_next;
  logic [NUM_W-1:0]  den_next;
  logic              half_next;
  meta_t             meta_next;
  logic              r_valid;
  logic [ROOT_W-1:0] r_root;
  meta_t             r_meta;
  logic [ROOT_W:0]   k_sum;
  logic [COEF_W-1:0] k;
  logic [COEF_W-1:0] coef;

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_comb begin
    int l1, m1, l2, m2, n, d, am1, am2;
    logic sgn_ok;
    l1 = int'(req.l_bra);
    m1 = int'(req.m_bra);
    l2 = int'(req.l_ket);
    m2 = int'(req.m_ket);
    am1 = m1 < 0 ? -m1 : m1;
    am2 = m2 < 0 ? -m2 : m2;
    n = 0;
    d = 1;
    sgn_ok = 1'b0;
    half_next = 1'b1;
    meta_next.bad = (am1 > l1) || (am2 > l2);
    meta_next.imag = (req.operation == AXIS_Y);
    meta_next.neg = 1'b0;
    if (!meta_next.bad && (req.operation == AXIS_X || req.operation == AXIS_Y)) begin
      if (m1 == m2 + 1 && l1 == l2 + 1) begin
        n = (l2 + m2 + 1) * (l2 + m2 + 2);
        d = (2 * l2 + 1) * (2 * l2 + 3);
        sgn_ok = 1'b1;
        meta_next.neg = (req.operation == AXIS_X);
      end else if (m1 == m2 + 1 && l1 == l2 - 1) begin
        n = (l2 - m2) * (l2 - m2 - 1);
        d = (2 * l2 - 1) * (2 * l2 + 1);
        sgn_ok = 1'b1;
        meta_next.neg = (req.operation == AXIS_Y);
      end else if (m1 == m2 - 1 && l1 == l2 + 1) begin
        n = (l2 - m2 + 1) * (l2 - m2 + 2);
        d = (2 * l2 + 1) * (2 * l2 + 3);
        sgn_ok = 1'b1;
      end else if (m1 == m2 - 1 && l1 == l2 - 1) begin
        n = (l2 + m2) * (l2 + m2 - 1);
        d = (2 * l2 - 1) * (2 * l2 + 1);
        sgn_ok = 1'b1;
        meta_next.neg = 1'b1;
      end
    end else if (!meta_next.bad && req.operation == AXIS_Z && m1 == m2) begin
      half_next = 1'b0;
      if (l1 == l2 + 1) begin
        n = (l2 - m2 + 1) * (l2 + m2 + 1);
        d = (2 * l2 + 1) * (2 * l2 + 3);
        sgn_ok = 1'b1;
      end else if (l1 == l2 - 1) begin
        n = (l2 - m2) * (l2 + m2);
        d = (2 * l2 + 1) * (2 * l2 - 1);
        sgn_ok = 1'b1;
      end
    end
    num_next = sgn_ok ? n[NUM_W-1:0] : '0;
    den_next = sgn_ok ? d[NUM_W-1:0] : NUM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req.valid;
    end
    if (en) begin
      num0  <= num_next;
      den0  <= den_next;
      half0 <= half_next;
      meta0 <= meta_next;
    end
  end

  dac_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .num       (num0),
    .den       (den0),
    .half      (half0),
    .in_meta   (meta0),
    .out_valid (r_valid),
    .root      (r_root),
    .out_meta  (r_meta)
  );

  // nearest k with (2k-1)^2 within the quotient
  assign k_sum = {1'b0, r_root} + (ROOT_W+1)'(1);
  assign k     = COEF_W'(k_sum[ROOT_W:1]);
  assign coef  = r_meta.neg ? COEF_W'(-k) : k;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= r_valid;
    end
    if (en) begin
      rsp.coef_real <= r_meta.imag ? '0 : coef;
      rsp.coef_imag <= r_meta.imag ? coef : '0;
      rsp.invalid   <= r_meta.bad;
    end
  end

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.invalid |-> rsp.coef_real == '0 && rsp.coef_imag == '0)
    else $error("invalid item with nonzero coefficient");
  a_one_part: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.coef_real == '0 || rsp.coef_imag == '0)
    else $error("both parts nonzero");
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid after reset");
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken during stall");
`endif
endmodule
